### rtl/fpst_pkg.sv
`default_nettype none

package fpst_pkg;

    // Tree geometry
    localparam int MAX_POSITIONS = 1024;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = 11;
    localparam int IDX_W         = POS_W + 1;
    localparam int DATA_W        = 32;

    // Configuration port
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'(MAX_POSITIONS);

    // Operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic issue;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_more;
        logic clear_last;
        logic is_query;
    } status_t;

endpackage

`default_nettype wire

### rtl/fpst_req_if.sv
`default_nettype none

interface fpst_req_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [fpst_pkg::POS_W-1:0]         position;
    logic signed [fpst_pkg::DATA_W-1:0] delta;

    modport source (output valid, output op, output position, output delta, input ready);
    modport sink   (input valid, input op, input position, input delta, output ready);
endinterface

`default_nettype wire

### rtl/fpst_rsp_if.sv
`default_nettype none

interface fpst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [fpst_pkg::DATA_W-1:0] prefix_sum;

    modport source (output valid, output prefix_sum, input ready);
    modport sink   (input valid, input prefix_sum, output ready);
endinterface

`default_nettype wire

### rtl/fpst_ram.sv
`default_nettype none

module fpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/fpst_ctrl.sv
`default_nettype none

module fpst_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire fpst_pkg::status_t st,
    output fpst_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence clearing, request intake, tree walk and result hand-off
    always_comb
    begin
        state_next   = state_reg;
        cmd.clear    = 1'b0;
        cmd.load     = 1'b0;
        cmd.issue    = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (st.walk_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (st.is_query)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fpst_dpath.sv
`default_nettype none

module fpst_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               op,
    input  wire logic [fpst_pkg::POS_W-1:0]         position,
    input  wire logic signed [fpst_pkg::DATA_W-1:0] delta,
    input  wire logic [fpst_pkg::POS_W-1:0]         limit,
    input  wire fpst_pkg::cmd_t                     cmd,
    output fpst_pkg::status_t                       st,
    output logic signed [fpst_pkg::DATA_W-1:0]      prefix_sum
);

    logic [fpst_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [fpst_pkg::IDX_W-1:0]  idx_low, idx_start, idx_lim;
    logic [fpst_pkg::POS_W-1:0]  qpos;
    logic                        op_reg;
    logic [fpst_pkg::DATA_W-1:0] delta_reg;
    logic [fpst_pkg::DATA_W-1:0] sum_reg, sum_next;
    logic [fpst_pkg::DATA_W-1:0] out_reg;
    logic                        pend_reg;
    logic [fpst_pkg::ADDR_W-1:0] pend_addr_reg;
    logic [fpst_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [fpst_pkg::ADDR_W-1:0] rd_addr;
    logic [fpst_pkg::IDX_W-1:0]  idx_dec;
    logic                        ram_we;
    logic [fpst_pkg::ADDR_W-1:0] ram_waddr;
    logic [fpst_pkg::DATA_W-1:0] ram_wdata;
    logic [fpst_pkg::DATA_W-1:0] ram_rdata;

    // Walk bounds and start index
    assign idx_lim   = {1'b0, limit};
    assign qpos      = (position > limit) ? limit : position;
    assign idx_start = (op == fpst_pkg::OP_QUERY) ? {1'b0, qpos} : {1'b0, position};
    assign idx_low   = idx_reg & (~idx_reg + fpst_pkg::IDX_W'(1));
    assign idx_dec   = idx_reg - fpst_pkg::IDX_W'(1);
    assign rd_addr   = idx_dec[fpst_pkg::ADDR_W-1:0];

    // Update climbs while inside the limit, query descends to zero
    assign st.walk_more  = (idx_reg != '0) &&
                           ((op_reg == fpst_pkg::OP_QUERY) || (idx_reg <= idx_lim));
    assign st.is_query   = (op_reg == fpst_pkg::OP_QUERY);
    assign st.clear_last = &clr_cnt_reg;

    // Advance the index along the tree
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = idx_start;
        end
        else if (cmd.issue)
        begin
            idx_next = (op_reg == fpst_pkg::OP_QUERY) ? idx_reg - idx_low : idx_reg + idx_low;
        end
    end

    // Accumulate the node read in the previous cycle
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.load)
        begin
            sum_next = '0;
        end
        else if (pend_reg && (op_reg == fpst_pkg::OP_QUERY))
        begin
            sum_next = sum_reg + ram_rdata;
        end
    end

    // Write back the updated node, or zero during the clearing pass
    assign ram_we    = cmd.clear || (pend_reg && (op_reg == fpst_pkg::OP_UPDATE));
    assign ram_waddr = cmd.clear ? clr_cnt_reg : pend_addr_reg;
    assign ram_wdata = cmd.clear ? '0 : ram_rdata + delta_reg;

    fpst_ram #(
        .WIDTH (fpst_pkg::DATA_W),
        .DEPTH (fpst_pkg::MAX_POSITIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            op_reg      <= fpst_pkg::OP_UPDATE;
            idx_reg     <= '0;
        end
        else
        begin
            pend_reg <= cmd.issue;
            idx_reg  <= idx_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + fpst_pkg::ADDR_W'(1);
            end
            if (cmd.load)
            begin
                op_reg <= op;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.issue)
        begin
            pend_addr_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            delta_reg <= delta;
        end
        if (cmd.out_load)
        begin
            out_reg <= sum_reg;
        end
    end

    assign prefix_sum = out_reg;

endmodule

`default_nettype wire

### rtl/fenwick_prefix_sum_tree.sv
`default_nettype none
// Reset starts a clearing pass that zeroes all 1024 entries of the tree; no request is taken meanwhile.
// One RAM read per tree node visited (k nodes, at most 11 for the 1024-entry store).
// Update: the next request is taken once the walk has written back its last node.
// Query: the result is loaded when the walk ends and the output slot is free; the next request is taken after that.
// The result sits in an output register, so a new request is taken while it waits.

module fenwick_prefix_sum_tree (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    fpst_req_if.sink                                req,
    fpst_rsp_if.source                              rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fpst_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [fpst_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [fpst_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    logic [fpst_pkg::POS_W-1:0] limit_reg;
    logic [fpst_pkg::POS_W-1:0] limit_eff;
    logic                       cfg_wr;
    fpst_pkg::cmd_t             cmd;
    fpst_pkg::status_t          st;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[fpst_pkg::APB_ADDR_W-1] == 1'b0);
    assign prdata = (paddr[fpst_pkg::APB_ADDR_W-1] == 1'b0) ?
                    {{(fpst_pkg::APB_DATA_W - fpst_pkg::POS_W){1'b0}}, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fpst_pkg::LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[fpst_pkg::POS_W-1:0];
        end
    end

    // Saturate the limit at the store depth
    assign limit_eff = (limit_reg > fpst_pkg::POS_W'(fpst_pkg::MAX_POSITIONS)) ?
                       fpst_pkg::POS_W'(fpst_pkg::MAX_POSITIONS) : limit_reg;

    fpst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    fpst_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (req.op),
        .position   (req.position),
        .delta      (req.delta),
        .limit      (limit_eff),
        .cmd        (cmd),
        .st         (st),
        .prefix_sum (rsp.prefix_sum)
    );

endmodule

`default_nettype wire
